### rtl/nbs_pkg.sv
// ----------------------------------------------------------------------------
// nbs_pkg
// Shared types and codes of the named buffer store: request and response
// payloads, operation and status codes.
// ----------------------------------------------------------------------------
package nbs_pkg;

    localparam int NAME_BYTES = 12;

    typedef enum logic [1:0] {
        OP_PUT_START = 2'd0,
        OP_PUT_DATA  = 2'd1,
        OP_READ      = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_BYTES = 2'd1,
        ST_NO_SLOT  = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [63:0] name_low;
        logic [31:0] name_high;
        logic [10:0] length;
        logic [9:0]  offset;
        logic [7:0]  data_byte;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [10:0] size;
        logic [7:0]  read_byte;
    } t_rsp;

endpackage

### rtl/nbs_chan_if.sv
// ----------------------------------------------------------------------------
// nbs_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface nbs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/nbs_ram.sv
// ----------------------------------------------------------------------------
// nbs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/named_buffer_store_compacting_top.sv
// ----------------------------------------------------------------------------
// named_buffer_store_compacting_top
// Slot table of named byte buffers sharing one byte store, compacted through
// a scratch store on each put_start with a nonzero name and length.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | result
//  i_req    | in  | op, name_low, name_high, length, offset, byte   | -
//  o_rsp    | out | status, found, size, read_byte                  | put_start, read
//
//  put_data: written straight from idle. read: a walk of the slot table.
//  put_start: a walk of the slot table with the compaction copy, then the
//  copy back through the byte store port.
//  clear and reset: a sweep over max(SLOTS, STORE_BYTES) addresses, with no
//  request taken. A new request is taken while a response waits on o_rsp.
// ----------------------------------------------------------------------------
module named_buffer_store_compacting_top #(
    parameter int SLOTS       = 16,
    parameter int STORE_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbs_chan_if.sink    i_req,
    nbs_chan_if.source  o_rsp
);
    localparam int AW    = $clog2(STORE_BYTES);
    localparam int UW    = AW + 1;
    localparam int SAW   = $clog2(SLOTS);
    localparam int SW    = ((UW > 11) ? UW : 11) + 1;
    localparam int CLR_N = (SLOTS > STORE_BYTES) ? SLOTS : STORE_BYTES;
    localparam int CW    = $clog2(CLR_N);

    typedef struct packed {
        logic [63:0]   nlo;
        logic [31:0]   nhi;
        logic [10:0]   len;
        logic [AW-1:0] pos;
    } t_ent;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_CMP_RD, S_CMP_EV, S_COPY, S_NEXT, S_CB, S_FIN,
        S_RD_RD, S_RD_EV, S_RD_BYTE, S_RD_Q, S_DONE
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_c;
    logic [SAW-1:0]  r_s;
    logic [SAW-1:0]  r_free;
    logic            r_free_v;
    logic            r_drop;
    logic [UW-1:0]   r_used;
    logic [AW-1:0]   r_src;
    logic [10:0]     r_clen;
    logic [10:0]     r_k;
    logic            r_cp_v;
    logic            r_cp_zero;
    logic [AW-1:0]   r_cp_dst;
    logic [AW-1:0]   r_a;
    logic            r_cb_v;
    logic            r_cb_live;
    logic [AW-1:0]   r_cb_addr;
    logic [63:0]     r_nlo;
    logic [31:0]     r_nhi;
    logic [10:0]     r_len;
    logic [9:0]      r_off;
    logic [AW-1:0]   r_rdaddr;
    logic [UW-1:0]   r_waddr;
    logic [10:0]     r_rem;
    logic            r_zs;
    nbs_pkg::t_rsp   r_res;
    nbs_pkg::t_rsp   r_rsp;
    logic            r_rsp_v;

    // memory ports
    logic            tbl_we;
    logic [SAW-1:0]  tbl_waddr;
    t_ent            tbl_wdata;
    t_ent            tbl_q;
    logic            st_we;
    logic [AW-1:0]   st_waddr;
    logic [7:0]      st_wdata;
    logic [AW-1:0]   st_raddr;
    logic [7:0]      st_q;
    logic [7:0]      scr_q;

    logic [95:0]     raw_name;
    logic [95:0]     canon;
    logic            zflag;
    logic            accept;
    logic            hit;
    logic            live;
    logic            fit;
    logic            keep;
    logic            over;
    logic [SW-1:0]   src_sum;
    logic [SW-1:0]   dst_sum;
    logic [SW-1:0]   rd_sum;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_v;
    assign o_rsp.payload = r_rsp;

    // bytes after the first zero byte of the name count as zero
    always_comb begin
        raw_name = {i_req.payload.name_high, i_req.payload.name_low};
        zflag    = 1'b0;
        canon    = '0;
        for (int i = 0; i < nbs_pkg::NAME_BYTES; i++) begin
            canon[8*i +: 8] = zflag ? 8'd0 : raw_name[8*i +: 8];
            if (raw_name[8*i +: 8] == 8'd0) begin
                zflag = 1'b1;
            end
        end
    end

    assign live    = (tbl_q.len != 11'd0);
    assign hit     = live && (tbl_q.nlo == r_nlo) && (tbl_q.nhi == r_nhi);
    assign fit     = (SW'(r_used) + SW'(tbl_q.len)) <= SW'(STORE_BYTES);
    assign keep    = live && !(hit && !r_drop) && fit;
    assign over    = (SW'(r_used) + SW'(r_len)) > SW'(STORE_BYTES);
    assign src_sum = SW'(r_src) + SW'(r_k);
    assign dst_sum = SW'(r_used) + SW'(r_k);
    assign rd_sum  = SW'(tbl_q.pos) + SW'(r_off);

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_s;
        tbl_wdata = '0;
        st_we     = 1'b0;
        st_waddr  = r_cb_addr;
        st_wdata  = r_cb_live ? scr_q : 8'd0;
        st_raddr  = src_sum[AW-1:0];
        case (r_state)
            S_CLR: begin
                tbl_we    = ({1'b0, r_c} < (CW + 1)'(SLOTS));
                tbl_waddr = r_c[SAW-1:0];
                st_we     = 1'b1;
                st_waddr  = r_c[AW-1:0];
                st_wdata  = 8'd0;
            end
            S_CMP_EV: begin
                tbl_we = 1'b1;
                if (keep) begin
                    tbl_wdata     = tbl_q;
                    tbl_wdata.pos = r_used[AW-1:0];
                end
            end
            S_FIN: begin
                // last byte of the copy back lands here
                st_we     = r_cb_v;
                tbl_we    = !over && r_free_v;
                tbl_waddr = r_free;
                tbl_wdata = '{nlo: r_nlo, nhi: r_nhi, len: r_len, pos: r_used[AW-1:0]};
            end
            S_RD_BYTE: begin
                st_raddr = r_rdaddr;
            end
            S_IDLE: begin
                st_we    = accept && (i_req.payload.op == nbs_pkg::OP_PUT_DATA)
                           && (r_rem != 11'd0) && (r_waddr < UW'(STORE_BYTES));
                st_waddr = r_waddr[AW-1:0];
                st_wdata = r_zs ? 8'd0 : i_req.payload.data_byte;
            end
            default: begin
                st_we = r_cb_v;
            end
        endcase
    end

    nbs_ram #(.WIDTH($bits(t_ent)), .DEPTH(SLOTS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_s),
        .o_rdata (tbl_q)
    );

    nbs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    nbs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (r_cp_v),
        .i_waddr (r_cp_dst),
        .i_wdata (r_cp_zero ? 8'd0 : st_q),
        .i_raddr (r_a),
        .o_rdata (scr_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_c     <= '0;
            r_rsp_v <= 1'b0;
            r_rem   <= '0;
            r_zs    <= 1'b0;
            r_cp_v  <= 1'b0;
            r_cb_v  <= 1'b0;
        end else begin
            r_cp_v <= 1'b0;
            r_cb_v <= 1'b0;
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_rsp_v <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    if (r_c == CW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_nlo <= canon[63:0];
                        r_nhi <= canon[95:64];
                        r_len <= i_req.payload.length;
                        r_off <= i_req.payload.offset;
                        r_s   <= '0;
                        case (i_req.payload.op)
                            nbs_pkg::OP_PUT_START: begin
                                r_rem    <= '0;
                                r_zs     <= 1'b0;
                                r_used   <= '0;
                                r_drop   <= 1'b0;
                                r_free_v <= 1'b0;
                                if (canon == 96'd0 || i_req.payload.length == 11'd0) begin
                                    r_res   <= '{status: nbs_pkg::ST_BAD, found: 1'b0,
                                                 size: 11'd0, read_byte: 8'd0};
                                    r_state <= S_DONE;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= S_CMP_RD;
                                end
                            end
                            nbs_pkg::OP_PUT_DATA: begin
                                if (r_rem != 11'd0) begin
                                    if (i_req.payload.data_byte == 8'd0) begin
                                        r_zs <= 1'b1;
                                    end
                                    r_waddr <= r_waddr + 1'b1;
                                    r_rem   <= r_rem - 1'b1;
                                end
                            end
                            nbs_pkg::OP_READ: begin
                                r_res   <= '0;
                                r_state <= S_RD_RD;
                            end
                            default: begin
                                r_rem   <= '0;
                                r_zs    <= 1'b0;
                                r_c     <= '0;
                                r_state <= S_CLR;
                            end
                        endcase
                    end
                end
                S_CMP_RD: begin
                    r_state <= S_CMP_EV;
                end
                S_CMP_EV: begin
                    if (hit) begin
                        r_drop <= 1'b1;
                    end
                    if (keep) begin
                        r_src   <= tbl_q.pos;
                        r_clen  <= tbl_q.len;
                        r_k     <= '0;
                        r_state <= S_COPY;
                    end else begin
                        if (!r_free_v) begin
                            r_free   <= r_s;
                            r_free_v <= 1'b1;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_COPY: begin
                    if (r_k != r_clen) begin
                        r_k       <= r_k + 1'b1;
                        r_cp_v    <= 1'b1;
                        r_cp_dst  <= dst_sum[AW-1:0];
                        r_cp_zero <= (src_sum >= SW'(STORE_BYTES));
                    end else begin
                        r_used  <= dst_sum[UW-1:0];
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_s == SAW'(SLOTS - 1)) begin
                        r_a     <= '0;
                        r_state <= S_CB;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_CMP_RD;
                    end
                end
                S_CB: begin
                    r_cb_v    <= 1'b1;
                    r_cb_addr <= r_a;
                    r_cb_live <= (UW'(r_a) < r_used);
                    if (r_a == AW'(STORE_BYTES - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_a <= r_a + 1'b1;
                    end
                end
                S_FIN: begin
                    if (over) begin
                        r_res.status <= nbs_pkg::ST_NO_BYTES;
                    end else if (!r_free_v) begin
                        r_res.status <= nbs_pkg::ST_NO_SLOT;
                    end else begin
                        r_res.status <= nbs_pkg::ST_OK;
                        r_waddr      <= r_used;
                        r_rem        <= r_len;
                    end
                    r_state <= S_DONE;
                end
                S_RD_RD: begin
                    r_state <= S_RD_EV;
                end
                S_RD_EV: begin
                    if (hit) begin
                        r_res.found <= 1'b1;
                        r_res.size  <= tbl_q.len;
                        if (({1'b0, r_off} < tbl_q.len) && (rd_sum < SW'(STORE_BYTES))) begin
                            r_rdaddr <= rd_sum[AW-1:0];
                            r_state  <= S_RD_BYTE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (r_s == SAW'(SLOTS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_RD_RD;
                    end
                end
                S_RD_BYTE: begin
                    r_state <= S_RD_Q;
                end
                S_RD_Q: begin
                    r_res.read_byte <= st_q;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (!r_rsp_v || o_rsp.ready) begin
                        r_rsp_v <= 1'b1;
                        r_rsp   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

### rtl/nbs_checker.sv
// ----------------------------------------------------------------------------
// nbs_checker
// Port-level checks of the named buffer store, bound to the top level.
// ----------------------------------------------------------------------------
module nbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [1:0] i_req_op,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready
);
    logic req_acc;
    assign req_acc = i_req_valid && i_req_ready;

    // response held until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // reset starts the clearing sweep
    a_reset_sweep: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !i_req_ready)
        else $error("request taken during clearing sweep");

    // clear request blocks the input
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req_op == nbs_pkg::OP_CLEAR |=> !i_req_ready)
        else $error("request taken right after clear");

    // put_data gives no response
    a_data_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req_op == nbs_pkg::OP_PUT_DATA |=> !$rose(i_rsp_valid))
        else $error("response after put_data");

    // put_start and read keep the block busy
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (i_req_op == nbs_pkg::OP_PUT_START || i_req_op == nbs_pkg::OP_READ)
        |=> !i_req_ready)
        else $error("request taken during table walk");
endmodule

bind named_buffer_store_compacting_top nbs_checker u_nbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.payload.op),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready)
);

### verif/named_buffer_store_compacting_top_test.sv
// ----------------------------------------------------------------------------
// named_buffer_store_compacting_top_test
// Drives put, data, read and clear requests into the named buffer store,
// predicts every response from a private copy of the slot table and byte
// store, and compares whole responses in order.
// ----------------------------------------------------------------------------
module named_buffer_store_compacting_top_test;
    import nbs_pkg::*;

    localparam int SLOTS       = 16;
    localparam int STORE_BYTES = 1024;
    localparam int IDLE_LIMIT  = 20000;

    logic i_clk;
    logic i_rst_n;

    nbs_chan_if #(.T(t_req)) req_if ();
    nbs_chan_if #(.T(t_rsp)) rsp_if ();

    named_buffer_store_compacting_top #(
        .SLOTS       (SLOTS),
        .STORE_BYTES (STORE_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // predicted state of the store
    logic [63:0] name_lo_tbl [SLOTS];
    logic [31:0] name_hi_tbl [SLOTS];
    int          len_tbl     [SLOTS];
    int          pos_tbl     [SLOTS];
    logic [7:0]  store_mem   [STORE_BYTES];
    logic [7:0]  pack_mem    [STORE_BYTES];
    int          wr_addr;
    int          wr_left;
    bit          wr_zero;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   mismatches;
    int   sent_items;
    bit   hold_for_drain;
    bit   driver_done;
    bit   timed_out;
    bit   req_accepted;
    int   idle_cycles;
    int   req_gap;
    int   rsp_gap;

    // known names for well-formed traffic
    logic [63:0] pool_lo [8];
    logic [31:0] pool_hi [8];

    task automatic clear_store();
        for (int s = 0; s < SLOTS; s++) begin
            name_lo_tbl[s] = '0;
            name_hi_tbl[s] = '0;
            len_tbl[s]     = 0;
            pos_tbl[s]     = 0;
        end
        for (int k = 0; k < STORE_BYTES; k++) store_mem[k] = '0;
        wr_addr = 0;
        wr_left = 0;
        wr_zero = 1'b0;
    endtask

    function automatic logic [95:0] canon_name(logic [63:0] lo, logic [31:0] hi);
        logic [95:0] n;
        bit          z;
        n = {hi, lo};
        z = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (z) n[8*i +: 8] = 8'h00;
            if (n[8*i +: 8] == 8'h00) z = 1'b1;
        end
        return n;
    endfunction

    function automatic int lookup_slot(logic [95:0] n);
        for (int s = 0; s < SLOTS; s++)
            if (len_tbl[s] != 0 && name_lo_tbl[s] == n[63:0] && name_hi_tbl[s] == n[95:64])
                return s;
        return SLOTS;
    endfunction

    function automatic int pack_buffers();
        int used;
        used = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (len_tbl[s] != 0 && used + len_tbl[s] <= STORE_BYTES) begin
                for (int k = 0; k < len_tbl[s]; k++)
                    pack_mem[used + k] = (pos_tbl[s] + k < STORE_BYTES) ?
                                         store_mem[pos_tbl[s] + k] : 8'h00;
                pos_tbl[s] = used;
                used += len_tbl[s];
            end else begin
                len_tbl[s] = 0;
                name_lo_tbl[s] = '0;
                name_hi_tbl[s] = '0;
                pos_tbl[s] = 0;
            end
        end
        for (int k = 0; k < STORE_BYTES; k++) store_mem[k] = (k < used) ? pack_mem[k] : 8'h00;
        return used;
    endfunction

    task automatic predict_store(input t_req r);
        logic [95:0] n;
        t_rsp        rsp;
        int          s;
        int          used;
        int          free_slot;
        n   = canon_name(r.name_low, r.name_high);
        rsp = '0;
        case (r.op)
            OP_PUT_START: begin
                wr_left = 0;
                wr_zero = 1'b0;
                if (n == '0 || r.length == 0) begin
                    rsp.status = ST_BAD;
                end else begin
                    s = lookup_slot(n);
                    if (s < SLOTS) len_tbl[s] = 0;
                    used = pack_buffers();
                    free_slot = SLOTS;
                    for (int k = SLOTS - 1; k >= 0; k--) if (len_tbl[k] == 0) free_slot = k;
                    if (STORE_BYTES - used < int'(r.length)) begin
                        rsp.status = ST_NO_BYTES;
                    end else if (free_slot == SLOTS) begin
                        rsp.status = ST_NO_SLOT;
                    end else begin
                        name_lo_tbl[free_slot] = n[63:0];
                        name_hi_tbl[free_slot] = n[95:64];
                        len_tbl[free_slot]     = r.length;
                        pos_tbl[free_slot]     = used;
                        wr_addr = used;
                        wr_left = r.length;
                        rsp.status = ST_OK;
                    end
                end
                expected_rsps.push_back(rsp);
            end
            OP_PUT_DATA: begin
                if (wr_left != 0) begin
                    if (wr_addr < STORE_BYTES) store_mem[wr_addr] = wr_zero ? 8'h00 : r.data_byte;
                    if (r.data_byte == 8'h00) wr_zero = 1'b1;
                    wr_addr++;
                    wr_left--;
                end
            end
            OP_READ: begin
                rsp.status = ST_OK;
                s = lookup_slot(n);
                if (s < SLOTS) begin
                    rsp.found = 1'b1;
                    rsp.size  = 11'(len_tbl[s]);
                    if (int'(r.offset) < len_tbl[s] && pos_tbl[s] + r.offset < STORE_BYTES)
                        rsp.read_byte = store_mem[pos_tbl[s] + r.offset];
                end
                expected_rsps.push_back(rsp);
            end
            default: clear_store();
        endcase
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic t_req make_req(t_op op, logic [63:0] lo, logic [31:0] hi,
                                      int len, int off, int data);
        t_req r;
        r.op = op;
        r.name_low = lo;
        r.name_high = hi;
        r.length = 11'(len);
        r.offset = 10'(off);
        r.data_byte = 8'(data);
        return r;
    endfunction

    task automatic queue_put(int idx, int len, bit with_zero);
        pending_reqs.push_back(make_req(OP_PUT_START, pool_lo[idx], pool_hi[idx], len,
                                        $urandom_range(1023), $urandom_range(255)));
        for (int k = 0; k < len; k++)
            pending_reqs.push_back(make_req(OP_PUT_DATA, {$urandom, $urandom}, $urandom,
                                            $urandom_range(2047), $urandom_range(1023),
                                            (with_zero && $urandom_range(7) == 0) ? 0 :
                                            $urandom_range(255, 1)));
    endtask

    task automatic queue_read(int idx, int len);
        int off;
        off = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(len);
        pending_reqs.push_back(make_req(OP_READ, pool_lo[idx], pool_hi[idx],
                                        $urandom_range(2047), off, $urandom_range(255)));
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_accepted) begin
            // hold the request until taken
        end else if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap <= req_gap - 1;
        end else if (hold_for_drain && pending_reqs.size() > 0
                     && pending_reqs[0].op == OP_CLEAR) begin
            req_if.valid <= 1'b0;
            if (expected_rsps.size() == 0 && !rsp_if.valid) hold_for_drain <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= pending_reqs.pop_front();
            req_gap <= gap_len();
        end else begin
            req_if.valid <= 1'b0;
            driver_done  <= 1'b1;
        end
    end

    // request acceptance feeds the predictor; monitor checks responses
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            req_accepted <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                predict_store(req_if.payload);
                sent_items <= sent_items + 1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %p", rsp_if.payload);
                end else begin
                    if (rsp_if.payload !== expected_rsps[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response mismatch: expected %p, got %p",
                                     expected_rsps[0], rsp_if.payload);
                    end
                    void'(expected_rsps.pop_front());
                end
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // response-side stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_if.valid && rsp_if.ready) rsp_gap <= gap_len();
        end
    end

    initial begin
        int idx;
        int len;
        int lens [8];
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        i_rst_n = 1'b0;
        req_gap = 0;
        rsp_gap = 0;
        mismatches = 0;
        sent_items = 0;
        idle_cycles = 0;
        driver_done = 1'b0;
        timed_out = 1'b0;
        req_accepted = 1'b0;
        clear_store();
        for (int i = 0; i < 8; i++) begin
            pool_lo[i] = {$urandom, $urandom};
            pool_hi[i] = $urandom;
            lens[i] = 0;
        end
        pool_lo[0] = 64'h0000_0000_0000_0041;  // one-byte name, rest zero
        pool_hi[0] = '0;
        pool_lo[1] = '1;                      // full 12-byte name
        pool_hi[1] = '1;
        pool_lo[2][15:8] = 8'h00;             // garbage after zero byte
        pool_lo[2][7:0] = 8'h5a;

        // directed part
        pending_reqs.push_back(make_req(OP_PUT_START, '0, '0, 5, 0, 0));     // zero name
        pending_reqs.push_back(make_req(OP_PUT_START, pool_lo[1], pool_hi[1], 0, 0, 0));
        pending_reqs.push_back(make_req(OP_PUT_DATA, '0, '0, 0, 0, 8'h77));  // stray data
        queue_put(1, 3, 1'b0);
        pending_reqs.push_back(make_req(OP_PUT_DATA, '0, '0, 0, 0, 8'hff));  // extra data
        queue_put(2, 4, 1'b0);
        pending_reqs.push_back(make_req(OP_PUT_DATA, '0, '0, 0, 0, 8'h00));  // zero byte
        pending_reqs.push_back(make_req(OP_READ, pool_lo[1], pool_hi[1], 0, 2, 0));
        pending_reqs.push_back(make_req(OP_READ, pool_lo[2] | 64'hff00_0000_0000_0000,
                                        '1, 0, 0, 0));  // same name after canonizing
        pending_reqs.push_back(make_req(OP_READ, pool_lo[1], pool_hi[1], 0, 1023, 0));
        pending_reqs.push_back(make_req(OP_READ, '0, '0, 0, 0, 0));          // zero name
        pending_reqs.push_back(make_req(OP_PUT_START, pool_lo[3], pool_hi[3], 1024, 0, 0));
        pending_reqs.push_back(make_req(OP_PUT_START, pool_lo[3], pool_hi[3], 2047, 0, 0));
        pending_reqs.push_back(make_req(OP_PUT_START, pool_lo[1], pool_hi[1], 1000, 0, 0));
        pending_reqs.push_back(make_req(OP_READ, pool_lo[2], pool_hi[2], 0, 0, 0));
        pending_reqs.push_back(make_req(OP_CLEAR, '1, '1, 2047, 1023, 8'hff));
        for (int s = 0; s < SLOTS + 1; s++)  // fill every slot, then one more
            pending_reqs.push_back(make_req(OP_PUT_START, {$urandom, $urandom} | 64'h1,
                                            $urandom, 1, 0, 0));
        pending_reqs.push_back(make_req(OP_CLEAR, '0, '0, 0, 0, 0));

        // random part, mostly well-formed puts with reads
        while (pending_reqs.size() < 2000) begin
            idx = $urandom_range(7);
            case ($urandom_range(19))
                0: pending_reqs.push_back(make_req(t_op'($urandom_range(3)),
                                                   {$urandom, $urandom}, $urandom,
                                                   $urandom_range(2047),
                                                   $urandom_range(1023),
                                                   $urandom_range(255)));
                1: pending_reqs.push_back(make_req(OP_CLEAR, '0, '0, 0, 0, 0));
                2: pending_reqs.push_back(make_req(OP_PUT_START, pool_lo[idx], pool_hi[idx],
                                                   $urandom_range(1024, 300), 0, 0));
                3, 4, 5, 6, 7: begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(12);
                    queue_put(idx, len, 1'b1);
                    lens[idx] = len;
                end
                default: queue_read(idx, lens[idx]);
            endcase
        end
        pending_reqs.push_back(make_req(OP_READ, pool_lo[0], pool_hi[0], 0, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        hold_for_drain = 1'b1;

        fork
            begin
                wait (driver_done && expected_rsps.size() == 0);
                repeat (3000) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out || mismatches != 0 || expected_rsps.size() != 0) begin
            $display("tb: failure");
        end else begin
            $display("tb: success");
        end
        $finish;
    end
endmodule
